// File: src/affine_to_pose_quaternion_top_defines.svh
// Assertion macros for the affine-to-pose block.
`ifndef AFFINE_TO_POSE_QUATERNION_TOP_DEFINES_SVH
`define AFFINE_TO_POSE_QUATERNION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ATPQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Check that cons holds in the cycle after ante.
`define ATPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ATPQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ATPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/atpq_pkg.sv
// Types and constants shared by the affine-to-pose block.
`timescale 1ns / 1ps
package atpq_pkg;
   typedef logic signed [31:0] q16_type;

   // Input word: one 3x4 affine transform, signed Q16.16.
   typedef struct packed {
      q16_type m00; q16_type m01; q16_type m02; q16_type t0;
      q16_type m10; q16_type m11; q16_type m12; q16_type t1;
      q16_type m20; q16_type m21; q16_type m22; q16_type t2;
   } atpq_req_type;

   // Result word: validity, position and quaternion, signed Q16.16.
   typedef struct packed {
      logic    valid_res;
      q16_type pos_x;  q16_type pos_y;  q16_type pos_z;
      q16_type quat_x; q16_type quat_y; q16_type quat_z; q16_type quat_w;
   } atpq_rsp_type;

   localparam int TOL_W = 17;
   localparam logic [TOL_W-1:0] TOL_RESET = 17'd3277;

   // Divider geometry: quotient bits, denominator and numerator magnitudes.
   localparam int QUO_W = 32;
   localparam int DEN_W = 50;
   localparam int NUM_W = 115;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;
   localparam int DIV_LAT = DIV_STAGES + 2;

   // Square root geometry.
   localparam int RAD_W = 47;
   localparam int ROOT_W = 24;
   localparam int ROOT_STEPS_PER_STAGE = 4;
   localparam int ROOT_STAGES = 6;
   localparam int DIF_W = 33;
   localparam int QUAT_SHIFT = 14;

   // Position branch result, handed to the dividers.
   typedef struct packed {
      logic             ok;
      logic             neg_x;
      logic             neg_y;
      logic             neg_z;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [NUM_W-1:0] num_z;
   } atpq_pos_type;

   // Quaternion branch result: root and skew differences.
   typedef struct packed {
      logic                    ok;
      logic [ROOT_W-1:0]       root;
      logic signed [DIF_W-1:0] dif_x;
      logic signed [DIF_W-1:0] dif_y;
      logic signed [DIF_W-1:0] dif_z;
   } atpq_root_type;

   // One job for a divider lane.
   typedef struct packed {
      logic             vld;
      logic             ok;
      logic             neg;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } atpq_div_job_type;
endpackage

// File: src/affine_to_pose_quaternion_top.sv
// Top level of the affine-to-pose block: input register, branches, divider lanes.
`timescale 1ns / 1ps
`include "affine_to_pose_quaternion_top_defines.svh"
// Converts one 3x4 affine transform per clock into a camera position and a
// quaternion. busy is always low: a word is taken in every cycle that start
// is high, and its result appears on rsp_data with rsp_strobe after
// 1 input register, 7 stages of cofactor/determinant and square-root
// work and 18 register stages in the divider lanes (a seed stage,
// 16 stages that retire two quotient bits each and a saturation stage).
// Results come in order, one per word, and cannot be held off.
// csr_ready is always high; write det_tolerance only while no word is in flight.
module affine_to_pose_quaternion_top import atpq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  atpq_req_type     req_data,
   output logic             rsp_strobe,
   output atpq_rsp_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TOL_W-1:0] csr_data
);
   logic                    in_vld_ff;
   atpq_req_type            in_data_ff;
   logic [TOL_W-1:0]        tol_ff;
   logic                    pos_vld;
   atpq_pos_type            pos_data;
   logic                    root_vld;
   atpq_root_type           root_data;
   logic                    all_ok;
   logic [DIF_W-1:0]        mag_x;
   logic [DIF_W-1:0]        mag_y;
   logic [DIF_W-1:0]        mag_z;
   atpq_div_job_type        job [6];
   logic                    quo_vld [6];
   logic signed [QUO_W-1:0] quo [6];
   logic                    wok_ff [DIV_LAT];
   logic [ROOT_W-1:0]       wroot_ff [DIV_LAT];
   logic                    lanes_same;
   logic                    rsp_zero;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Hold the tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   // Register the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= req_data;
   end

   atpq_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (in_vld_ff),
      .in_data (in_data_ff),
      .tol     (tol_ff),
      .out_vld (pos_vld),
      .out_pos (pos_data)
   );

   atpq_root u_root (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld_ff),
      .in_data  (in_data_ff),
      .out_vld  (root_vld),
      .out_root (root_data)
   );

   // Build the six divider jobs: three position, three quaternion
   always_comb begin
      all_ok = pos_data.ok && root_data.ok;
      mag_x  = root_data.dif_x[DIF_W-1] ? DIF_W'(-root_data.dif_x) : DIF_W'(root_data.dif_x);
      mag_y  = root_data.dif_y[DIF_W-1] ? DIF_W'(-root_data.dif_y) : DIF_W'(root_data.dif_y);
      mag_z  = root_data.dif_z[DIF_W-1] ? DIF_W'(-root_data.dif_z) : DIF_W'(root_data.dif_z);
      for (int k = 0; k < 6; k++) begin
         job[k].vld = pos_vld;
         job[k].ok  = all_ok;
      end
      for (int k = 0; k < 3; k++) begin
         job[k].den   = pos_data.den;
         job[k+3].den = DEN_W'(root_data.root);
      end
      job[0].num = pos_data.num_x;
      job[0].neg = pos_data.neg_x;
      job[1].num = pos_data.num_y;
      job[1].neg = pos_data.neg_y;
      job[2].num = pos_data.num_z;
      job[2].neg = pos_data.neg_z;
      job[3].num = NUM_W'({mag_x, {QUAT_SHIFT{1'b0}}});
      job[3].neg = root_data.dif_x[DIF_W-1];
      job[4].num = NUM_W'({mag_y, {QUAT_SHIFT{1'b0}}});
      job[4].neg = root_data.dif_y[DIF_W-1];
      job[5].num = NUM_W'({mag_z, {QUAT_SHIFT{1'b0}}});
      job[5].neg = root_data.dif_z[DIF_W-1];
   end

   for (genvar k = 0; k < 6; k++) begin : g_lane
      atpq_div u_div (
         .clock   (clock),
         .reset   (reset),
         .job     (job[k]),
         .out_vld (quo_vld[k]),
         .out_quo (quo[k])
      );
   end

   // Delay the root alongside the divider lanes
   always_ff @(posedge clock) begin
      wok_ff[0]   <= all_ok;
      wroot_ff[0] <= root_data.root;
      for (int s = 1; s < DIV_LAT; s++) begin
         wok_ff[s]   <= wok_ff[s-1];
         wroot_ff[s] <= wroot_ff[s-1];
      end
   end

   // Assemble the result word
   always_comb begin
      rsp_strobe         = quo_vld[0];
      rsp_data.valid_res = wok_ff[DIV_LAT-1];
      rsp_data.pos_x     = quo[0];
      rsp_data.pos_y     = quo[1];
      rsp_data.pos_z     = quo[2];
      rsp_data.quat_x    = quo[3];
      rsp_data.quat_y    = quo[4];
      rsp_data.quat_z    = quo[5];
      rsp_data.quat_w    = wok_ff[DIV_LAT-1] ? $signed(32'(wroot_ff[DIV_LAT-1])) : '0;
   end

   // Summarize lane agreement and an all-zero result word
   always_comb begin
      lanes_same = 1'b1;
      for (int k = 1; k < 6; k++) begin
         lanes_same = lanes_same && (quo_vld[k] == quo_vld[0]);
      end
      rsp_zero = rsp_data.pos_x == 0 && rsp_data.pos_y == 0 && rsp_data.pos_z == 0
                 && rsp_data.quat_x == 0 && rsp_data.quat_y == 0
                 && rsp_data.quat_z == 0 && rsp_data.quat_w == 0;
   end

   `ATPQ_ASSERT_IMPL(a_branch_align, clock, reset, 1'b1, pos_vld == root_vld)
   `ATPQ_ASSERT_IMPL(a_lanes_in_step, clock, reset, 1'b1, lanes_same)
   `ATPQ_ASSERT_IMPL(a_reject_zero, clock, reset, rsp_strobe && !rsp_data.valid_res, rsp_zero)
   `ATPQ_ASSERT_IMPL(a_w_tracks_valid, clock, reset, rsp_strobe, (rsp_data.quat_w != 0) == rsp_data.valid_res)
   `ATPQ_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, in_vld_ff)
endmodule

// File: src/atpq_div.sv
// Pipelined restoring divider lane with signed saturation to Q16.16.
`timescale 1ns / 1ps
module atpq_div import atpq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  atpq_div_job_type        job,
   output logic                    out_vld,
   output logic signed [QUO_W-1:0] out_quo
);
   localparam logic [QUO_W-1:0] SAT_HI = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] SAT_LO = 32'h8000_0000;

   logic             vld_ff [DIV_STAGES+1];
   logic             ok_ff  [DIV_STAGES+1];
   logic             neg_ff [DIV_STAGES+1];
   logic             ovf_ff [DIV_STAGES+1];
   logic [DEN_W-1:0] den_ff [DIV_STAGES+1];
   logic [DEN_W-1:0] rem_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES+1];
   logic             out_vld_ff;
   logic [QUO_W-1:0] out_quo_ff;
   logic [QUO_W-1:0] out_quo_in;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= job.vld;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         out_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   // Flag quotients of 2^32 or more, seed remainder with the high numerator bits
   always_ff @(posedge clock) begin
      ok_ff[0]  <= job.ok;
      neg_ff[0] <= job.neg;
      den_ff[0] <= job.den;
      ovf_ff[0] <= job.num >= NUM_W'({job.den, {QUO_W{1'b0}}});
      rem_ff[0] <= job.num[QUO_W +: DEN_W];
      quo_ff[0] <= job.num[QUO_W-1:0];
   end

   // Retire two quotient bits per stage
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         logic [DEN_W:0]   r;
         logic [DEN_W-1:0] rm;
         logic [QUO_W-1:0] qt;
         rm = rem_ff[g];
         qt = quo_ff[g];
         for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            r  = {rm, qt[QUO_W-1]};
            qt = {qt[QUO_W-2:0], 1'b0};
            if (r >= {1'b0, den_ff[g]}) begin
               r     = r - {1'b0, den_ff[g]};
               qt[0] = 1'b1;
            end
            rm = r[DEN_W-1:0];
         end
         rem_in = rm;
         quo_in = qt;
      end

      always_ff @(posedge clock) begin
         rem_ff[g+1] <= rem_in;
         quo_ff[g+1] <= quo_in;
         den_ff[g+1] <= den_ff[g];
         ok_ff[g+1]  <= ok_ff[g];
         neg_ff[g+1] <= neg_ff[g];
         ovf_ff[g+1] <= ovf_ff[g];
      end
   end

   // Apply sign and saturate; drop to zero for rejected transforms
   always_comb begin
      logic [QUO_W-1:0] q;
      q = quo_ff[DIV_STAGES];
      if (!ok_ff[DIV_STAGES]) begin
         out_quo_in = '0;
      end else if (!neg_ff[DIV_STAGES]) begin
         out_quo_in = (ovf_ff[DIV_STAGES] || q[QUO_W-1]) ? SAT_HI : q;
      end else begin
         out_quo_in = (ovf_ff[DIV_STAGES] || q > SAT_LO) ? SAT_LO : QUO_W'(-q);
      end
   end

   always_ff @(posedge clock) begin
      out_quo_ff <= out_quo_in;
   end

   assign out_vld = out_vld_ff;
   assign out_quo = $signed(out_quo_ff);
endmodule

// File: src/atpq_geom.sv
// Cofactors, determinant, tolerance test and position numerators.
`timescale 1ns / 1ps
module atpq_geom import atpq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  atpq_req_type     in_data,
   input  logic [TOL_W-1:0] tol,
   output logic             out_vld,
   output atpq_pos_type     out_pos
);
   localparam logic [98:0]      ONE_Q48 = 99'(1) << 48;
   localparam logic [TOL_W-1:0] TOL_ONE = 17'd65536;

   logic               vld_ff [6];
   logic               out_vld_ff;
   logic signed [31:0] opa [18];
   logic signed [31:0] opb [18];
   logic signed [63:0] prod_ff [18];
   logic signed [31:0] row0_1_ff [3];
   logic signed [31:0] tr_1_ff [3];
   logic signed [31:0] row0_2_ff [3];
   logic signed [31:0] tr_2_ff [3];
   logic signed [64:0] cof_ff [9];
   logic signed [64:0] pc [12];
   logic signed [31:0] px [12];
   logic signed [64:0] pp_hi_ff [12];
   logic signed [64:0] pp_lo_ff [12];
   logic signed [96:0] term_ff [12];
   logic signed [98:0] det_ff;
   logic signed [98:0] nsum_ff [3];
   logic [98:0]        adet_ff;
   logic               det_neg_ff;
   logic [98:0]        anum_ff [3];
   logic               nneg_ff [3];
   logic [98:0]        hi_b;
   logic [98:0]        lo_b;
   logic               det_ok;
   atpq_pos_type       pos_ff;
   atpq_pos_type       pos_in;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s < 6; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         out_vld_ff <= vld_ff[5];
      end
   end

   // Pick the operand pairs of the nine 2x2 cofactors
   always_comb begin
      opa[0]  = in_data.m11; opb[0]  = in_data.m22;
      opa[1]  = in_data.m12; opb[1]  = in_data.m21;
      opa[2]  = in_data.m12; opb[2]  = in_data.m20;
      opa[3]  = in_data.m10; opb[3]  = in_data.m22;
      opa[4]  = in_data.m10; opb[4]  = in_data.m21;
      opa[5]  = in_data.m11; opb[5]  = in_data.m20;
      opa[6]  = in_data.m02; opb[6]  = in_data.m21;
      opa[7]  = in_data.m01; opb[7]  = in_data.m22;
      opa[8]  = in_data.m00; opb[8]  = in_data.m22;
      opa[9]  = in_data.m02; opb[9]  = in_data.m20;
      opa[10] = in_data.m01; opb[10] = in_data.m20;
      opa[11] = in_data.m00; opb[11] = in_data.m21;
      opa[12] = in_data.m01; opb[12] = in_data.m12;
      opa[13] = in_data.m02; opb[13] = in_data.m11;
      opa[14] = in_data.m02; opb[14] = in_data.m10;
      opa[15] = in_data.m00; opb[15] = in_data.m12;
      opa[16] = in_data.m00; opb[16] = in_data.m11;
      opa[17] = in_data.m01; opb[17] = in_data.m10;
   end

   // Stage 1: 32x32 products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 18; k++) begin
         prod_ff[k] <= opa[k] * opb[k];
      end
      row0_1_ff[0] <= in_data.m00;
      row0_1_ff[1] <= in_data.m01;
      row0_1_ff[2] <= in_data.m02;
      tr_1_ff[0]   <= in_data.t0;
      tr_1_ff[1]   <= in_data.t1;
      tr_1_ff[2]   <= in_data.t2;
   end

   // Stage 2: cofactors in Q32.32
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         cof_ff[k] <= 65'(prod_ff[2*k]) - 65'(prod_ff[2*k+1]);
      end
      row0_2_ff <= row0_1_ff;
      tr_2_ff   <= tr_1_ff;
   end

   // Pair cofactors with row 0 for the determinant, with t for the adjugate sums
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pc[j] = cof_ff[j];
         px[j] = row0_2_ff[j];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pc[3+3*i+j] = cof_ff[3*j+i];
            px[3+3*i+j] = tr_2_ff[j];
         end
      end
   end

   // Stage 3: split each 65x32 product into two 33x32 partial products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 12; k++) begin
         pp_hi_ff[k] <= $signed(pc[k][64:32]) * px[k];
         pp_lo_ff[k] <= $signed({1'b0, pc[k][31:0]}) * px[k];
      end
   end

   // Stage 4: join the partial products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 12; k++) begin
         term_ff[k] <= (97'(pp_hi_ff[k]) <<< 32) + 97'(pp_lo_ff[k]);
      end
   end

   // Stage 5: determinant and adjugate-times-translation sums, Q48.48
   always_ff @(posedge clock) begin
      det_ff <= 99'(term_ff[0]) + 99'(term_ff[1]) + 99'(term_ff[2]);
      for (int i = 0; i < 3; i++) begin
         nsum_ff[i] <= 99'(term_ff[3+3*i]) + 99'(term_ff[4+3*i]) + 99'(term_ff[5+3*i]);
      end
   end

   // Stage 6: magnitudes; the position numerator is the negated sum
   always_ff @(posedge clock) begin
      adet_ff    <= det_ff[98] ? 99'(-det_ff) : 99'(det_ff);
      det_neg_ff <= det_ff[98];
      for (int i = 0; i < 3; i++) begin
         anum_ff[i] <= nsum_ff[i][98] ? 99'(-nsum_ff[i]) : 99'(nsum_ff[i]);
         nneg_ff[i] <= !nsum_ff[i][98] && (nsum_ff[i] != '0);
      end
   end

   // Stage 7: tolerance window on |det|, both bounds inclusive, zero rejected
   always_comb begin
      hi_b   = ONE_Q48 + (99'(tol) << 32);
      lo_b   = ONE_Q48 - (99'(tol) << 32);
      det_ok = !(adet_ff > hi_b) && !((tol < TOL_ONE) && (adet_ff < lo_b))
               && (adet_ff != '0);
      pos_in.ok    = det_ok;
      pos_in.neg_x = nneg_ff[0] ^ det_neg_ff;
      pos_in.neg_y = nneg_ff[1] ^ det_neg_ff;
      pos_in.neg_z = nneg_ff[2] ^ det_neg_ff;
      pos_in.den   = adet_ff[DEN_W-1:0];
      pos_in.num_x = {anum_ff[0], 16'h0000};
      pos_in.num_y = {anum_ff[1], 16'h0000};
      pos_in.num_z = {anum_ff[2], 16'h0000};
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign out_vld = out_vld_ff;
   assign out_pos = pos_ff;
endmodule

// File: src/atpq_root.sv
// Trace check, pipelined integer square root and quaternion skew differences.
`timescale 1ns / 1ps
module atpq_root import atpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  atpq_req_type  in_data,
   output logic          out_vld,
   output atpq_root_type out_root
);
   logic                    vld_ff [ROOT_STAGES+1];
   logic                    ok_ff  [ROOT_STAGES+1];
   logic [RAD_W-1:0]        rad_ff [ROOT_STAGES+1];
   logic [RAD_W-1:0]        res_ff [ROOT_STAGES+1];
   logic signed [DIF_W-1:0] dx_ff  [ROOT_STAGES+1];
   logic signed [DIF_W-1:0] dy_ff  [ROOT_STAGES+1];
   logic signed [DIF_W-1:0] dz_ff  [ROOT_STAGES+1];
   logic signed [34:0]      s_sum;
   logic                    s_ok;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ROOT_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s <= ROOT_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // One plus trace in Q16.16; usable only when positive
   always_comb begin
      s_sum = 35'sd65536 + 35'(in_data.m00) + 35'(in_data.m11) + 35'(in_data.m22);
      s_ok  = !s_sum[34] && (s_sum != '0);
   end

   // Stage 1: radicand S * 2^14 and skew differences
   always_ff @(posedge clock) begin
      ok_ff[0]  <= s_ok;
      rad_ff[0] <= s_ok ? {s_sum[32:0], {QUAT_SHIFT{1'b0}}} : '0;
      res_ff[0] <= '0;
      dx_ff[0]  <= 33'(in_data.m21) - 33'(in_data.m12);
      dy_ff[0]  <= 33'(in_data.m02) - 33'(in_data.m20);
      dz_ff[0]  <= 33'(in_data.m10) - 33'(in_data.m01);
   end

   // Resolve four root bits per stage, highest first
   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      logic [RAD_W-1:0] rad_in;
      logic [RAD_W-1:0] res_in;

      always_comb begin
         logic [RAD_W-1:0] r;
         logic [RAD_W-1:0] q;
         logic [RAD_W-1:0] b;
         logic [RAD_W:0]   trial;
         r = rad_ff[g];
         q = res_ff[g];
         for (int j = 0; j < ROOT_STEPS_PER_STAGE; j++) begin
            b     = RAD_W'(1) << (RAD_W - 1 - 2 * (g * ROOT_STEPS_PER_STAGE + j));
            trial = {1'b0, q} + {1'b0, b};
            if ({1'b0, r} >= trial) begin
               r = r - trial[RAD_W-1:0];
               q = (q >> 1) + b;
            end else begin
               q = q >> 1;
            end
         end
         rad_in = r;
         res_in = q;
      end

      always_ff @(posedge clock) begin
         rad_ff[g+1] <= rad_in;
         res_ff[g+1] <= res_in;
         ok_ff[g+1]  <= ok_ff[g];
         dx_ff[g+1]  <= dx_ff[g];
         dy_ff[g+1]  <= dy_ff[g];
         dz_ff[g+1]  <= dz_ff[g];
      end
   end

   assign out_vld        = vld_ff[ROOT_STAGES];
   assign out_root.ok    = ok_ff[ROOT_STAGES];
   assign out_root.root  = res_ff[ROOT_STAGES][ROOT_W-1:0];
   assign out_root.dif_x = dx_ff[ROOT_STAGES];
   assign out_root.dif_y = dy_ff[ROOT_STAGES];
   assign out_root.dif_z = dz_ff[ROOT_STAGES];
endmodule
